// ===== design/hid_report_edge_events_defines.svh =====
// Assertion macros for the HID report edge event block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef HID_REPORT_EDGE_EVENTS_DEFINES_SVH
`define HID_REPORT_EDGE_EVENTS_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge out of reset.
`define HRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true out of reset.
`define HRE_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define HRE_ASSERT(lbl, prop, msg)
`define HRE_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ===== design/hre_pkg.sv =====
// Package for the HID report edge event block: word types, control structs,
// constants and helper functions. No dependencies.
`default_nettype none

package hre_pkg;

  localparam int DEF_PORTS     = 2;
  localparam int DEF_KEY_SLOTS = 4;

  localparam int USAGE_W      = 8;
  localparam int MOD_BITS     = 8;
  localparam int REPORT_SLOTS = 4;   // key slots carried by one report
  localparam int SLOT_MAX     = 6;   // most key slots a build may keep

  localparam logic [USAGE_W-1:0] MOD_USAGE_BASE  = 8'hE0;
  localparam logic [USAGE_W-1:0] MIN_VALID_USAGE = 8'h04;
  localparam logic [1:0]         TYPE_KEYBOARD   = 2'd1;

  typedef struct packed {
    logic        port;
    logic [1:0]  device_type;
    logic [7:0]  modifier_byte;
    logic [31:0] key_report;
  } hre_in_t;

  typedef struct packed {
    logic [7:0] usage;
    logic [7:0] modifier_snapshot;
    logic       pressed;
    logic       last;
  } hre_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // capture input word
    logic eval;   // build event mask, update held state
    logic pop;    // drop the event on the output
  } hre_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;  // no events pending
    logic last;   // event on the output is the final one
  } hre_sts_t;

  // Empty slot and rollover codes never produce events.
  function automatic logic usage_valid(input logic [USAGE_W-1:0] u);
    return u >= MIN_VALID_USAGE;
  endfunction

endpackage

`default_nettype wire

// ===== design/hre_ctrl.sv =====
// Controller for the HID report edge event block: load, evaluate, emit.
// Depends on hre_pkg.
`default_nettype none

module hre_ctrl
  import hre_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  hre_sts_t sts_i,
  output hre_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_EMIT = 3'b100
  } hre_state_e;

  hre_state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.empty) begin
          state_d = ST_IDLE;
        end else begin
          out_valid_o = 1'b1;
          if (out_ready_i) begin
            cmd_o.pop = 1'b1;
            if (sts_i.last) state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/hre_datapath.sv =====
// Datapath for the HID report edge event block: report register, per-port
// held state, pending event mask and event select. Depends on hre_pkg.
`default_nettype none

module hre_datapath
  import hre_pkg::*;
#(
  parameter int PORTS     = DEF_PORTS,
  parameter int KEY_SLOTS = DEF_KEY_SLOTS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  hre_in_t  in_word_i,
  input  hre_cmd_t cmd_i,
  output hre_out_t out_word_o,
  output hre_sts_t sts_o
);

  localparam int EV_W = MOD_BITS + 2 * KEY_SLOTS;
  localparam int PW   = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int REL0 = MOD_BITS;
  localparam int PRS0 = MOD_BITS + KEY_SLOTS;

  hre_in_t report_q;

  logic [USAGE_W-1:0]  held_mods_q [PORTS];
  logic [USAGE_W-1:0]  held_keys_q [PORTS][KEY_SLOTS];
  logic [USAGE_W-1:0]  old_q [KEY_SLOTS];
  logic [MOD_BITS-1:0] snap_q;
  logic [EV_W-1:0]     mask_q;

  logic [PW-1:0]               port_idx;
  logic                        port_ok;
  logic                        is_kbd;
  logic [SLOT_MAX*USAGE_W-1:0] keys_ext;
  logic [USAGE_W-1:0]          cur [KEY_SLOTS];
  logic [USAGE_W-1:0]          old_rd [KEY_SLOTS];
  logic [MOD_BITS-1:0]         prev_mods;
  logic [KEY_SLOTS-1:0]        old_in_cur, cur_in_old;
  logic [EV_W-1:0]             mask_d;
  logic [MOD_BITS-1:0]         snap_d;
  logic [EV_W-1:0]             low_bit;

  // Evaluate the latched report against the port's held state.
  always_comb begin
    port_idx  = PW'(report_q.port);
    port_ok   = int'(report_q.port) < PORTS;
    is_kbd    = report_q.device_type == TYPE_KEYBOARD;
    keys_ext  = {report_q.key_report, {((SLOT_MAX - REPORT_SLOTS) * USAGE_W){1'b0}}};
    prev_mods = held_mods_q[port_idx];
    for (int i = 0; i < KEY_SLOTS; i++) begin
      cur[i]    = keys_ext[(SLOT_MAX - 1 - i) * USAGE_W +: USAGE_W];
      old_rd[i] = held_keys_q[port_idx][i];
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      old_in_cur[i] = 1'b0;
      cur_in_old[i] = 1'b0;
      for (int k = 0; k < KEY_SLOTS; k++) begin
        if (old_rd[i] == cur[k]) old_in_cur[i] = 1'b1;
        if (cur[i] == old_rd[k]) cur_in_old[i] = 1'b1;
      end
    end
    mask_d = '0;
    snap_d = '0;
    if (port_ok) begin
      if (is_kbd) begin
        snap_d                = report_q.modifier_byte;
        mask_d[MOD_BITS-1:0] = report_q.modifier_byte ^ prev_mods;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          mask_d[REL0 + i] = usage_valid(old_rd[i]) && !old_in_cur[i];
          mask_d[PRS0 + i] = usage_valid(cur[i]) && !cur_in_old[i];
        end
      end else begin
        // flush: release everything held
        mask_d[MOD_BITS-1:0] = prev_mods;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          mask_d[REL0 + i] = usage_valid(old_rd[i]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) report_q <= in_word_i;
    if (cmd_i.eval) begin
      snap_q <= snap_d;
      for (int i = 0; i < KEY_SLOTS; i++) old_q[i] <= old_rd[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      for (int p = 0; p < PORTS; p++) begin
        held_mods_q[p] <= '0;
        for (int s = 0; s < KEY_SLOTS; s++) held_keys_q[p][s] <= '0;
      end
    end else begin
      if (cmd_i.eval) begin
        mask_q <= mask_d;
        if (port_ok) begin
          held_mods_q[port_idx] <= is_kbd ? report_q.modifier_byte : '0;
          for (int s = 0; s < KEY_SLOTS; s++) begin
            held_keys_q[port_idx][s] <= is_kbd ? cur[s] : '0;
          end
        end
      end else if (cmd_i.pop) begin
        mask_q <= mask_q & (mask_q - EV_W'(1));
      end
    end
  end

  // Lowest pending event goes out first.
  always_comb begin
    low_bit    = mask_q & (~mask_q + EV_W'(1));
    out_word_o = '0;
    for (int i = 0; i < MOD_BITS; i++) begin
      if (low_bit[i]) begin
        out_word_o.usage   = USAGE_W'(MOD_USAGE_BASE + USAGE_W'(i));
        out_word_o.pressed = snap_q[i];
      end
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (low_bit[REL0 + i]) out_word_o.usage = old_q[i];
      if (low_bit[PRS0 + i]) begin
        out_word_o.usage   = cur[i];
        out_word_o.pressed = 1'b1;
      end
    end
    out_word_o.modifier_snapshot = snap_q;
    out_word_o.last              = (mask_q & (mask_q - EV_W'(1))) == '0;
    sts_o.empty                  = mask_q == '0;
    sts_o.last                   = out_word_o.last;
  end

endmodule

`default_nettype wire

// ===== design/hid_report_edge_events.sv =====
// HID boot-keyboard report to key edge events. Each input word is one report
// (port, device type, modifier byte, four key slots); the block compares it
// with the port's previous report and emits one output word per change:
// modifier bits low to high as usages 0xE0+bit, then released keys by old
// slot, then newly pressed keys by new slot. Usages below 0x04 are ignored.
// A non-keyboard device type releases all held modifiers and keys with a
// zero modifier snapshot and clears the port. The last word of a report has
// last set; a report with no changes produces no words. One report is in
// flight at a time, and a report yields at most 8 + 2*KEY_SLOTS events. The
// event walker sends one event per cycle from the pending mask while
// out_ready_i is high.
// Depends on hre_pkg, hre_ctrl, hre_datapath and the defines header.
`default_nettype none

`include "hid_report_edge_events_defines.svh"

module hid_report_edge_events
  import hre_pkg::*;
#(
  parameter int PORTS     = DEF_PORTS,      // ports with held state, 1..2
  parameter int KEY_SLOTS = DEF_KEY_SLOTS   // key slots kept per port, 1..6
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  hre_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output hre_out_t out_word_o
);

  hre_cmd_t cmd;
  hre_sts_t sts;

  // Sequencer: idle -> evaluate -> emit pending events -> idle.
  hre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Held per-port state, diff logic and the pending event mask.
  hre_datapath #(
    .PORTS     (PORTS),
    .KEY_SLOTS (KEY_SLOTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .out_word_o (out_word_o),
    .sts_o      (sts)
  );

  // Never take a report while events of the previous one are outstanding.
  `HRE_ASSERT_NEVER(a_ready_while_emitting, in_ready_o && out_valid_o, "ready during emit")
  // After a report is taken the block is busy and shows nothing in the next cycle.
  `HRE_ASSERT(a_busy_after_load, (in_valid_i && in_ready_o) |=> (!in_ready_o && !out_valid_o), "not busy after load")
  // Handing over the last word returns the block to idle.
  `HRE_ASSERT(a_idle_after_last, (out_valid_o && out_ready_i && out_word_o.last) |=> in_ready_o, "not idle after last")

endmodule

`default_nettype wire
